>>> rtl/mcet_pkg.sv
package mcet_pkg;

  // default widths of the coordinate and delta fields
  localparam int CoordBitsDef = 12;
  localparam int DeltaBitsDef = 9;

  // configuration register file
  localparam int CfgW    = 13;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 1'd1;

  localparam logic [CfgW-1:0] ScreenWidthRst  = 13'd1024;
  localparam logic [CfgW-1:0] ScreenHeightRst = 13'd768;

  // depth of the queue between front and back end
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    EvMove = 2'd0,
    EvDown = 2'd1,
    EvUp   = 2'd2
  } evt_kind_e;

  typedef enum logic [1:0] {
    BtnNone  = 2'd0,
    BtnLeft  = 2'd1,
    BtnRight = 2'd2
  } btn_sel_e;

  // classification of one report as handed from front to back end
  typedef struct packed {
    logic moved;
    logic left_chg;
    logic right_chg;
    logic left_lvl;
    logic right_lvl;
  } evt_flags_t;

endpackage

>>> rtl/mcet_front.sv
module mcet_front
  import mcet_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int DELTA_BITS = DeltaBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // report input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DELTA_BITS-1:0] delta_x_i,
  input  logic signed [DELTA_BITS-1:0] delta_y_i,
  input  logic                         left_level_i,
  input  logic                         right_level_i,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [CfgW-1:0]              cfg_wdata_i,
  // queue write side
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output logic [COORD_BITS-1:0]        q_pos_x_o,
  output logic [COORD_BITS-1:0]        q_pos_y_o,
  output evt_flags_t                   q_flags_o
);

  localparam int SumW  = ((COORD_BITS > DELTA_BITS) ? COORD_BITS : DELTA_BITS) + 2;
  localparam int WideW = ((COORD_BITS + 1) > CfgW) ? (COORD_BITS + 1) : CfgW;

  logic [CfgW-1:0]       width_q, width_d;
  logic [CfgW-1:0]       height_q, height_d;
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0] cur_y_q, cur_y_d;
  logic                  left_q, left_d;
  logic                  right_q, right_d;

  logic                  accept;
  logic [COORD_BITS-1:0] lim_x, lim_y;
  logic [COORD_BITS-1:0] new_x, new_y;
  evt_flags_t            flags;

  // largest coordinate for a screen size, with zero and oversize folded in
  function automatic logic [COORD_BITS-1:0] limit_m1(logic [CfgW-1:0] size);
    logic [WideW-1:0] sw;
    logic [WideW-1:0] top;
    sw  = WideW'(size);
    top = WideW'(1) << COORD_BITS;
    if (sw == '0) begin
      return '0;
    end else if (sw > top) begin
      return COORD_BITS'(top - WideW'(1));
    end else begin
      return COORD_BITS'(sw - WideW'(1));
    end
  endfunction

  // one axis: add the delta and clamp to 0 .. lim
  function automatic logic [COORD_BITS-1:0] clamp_axis(
    logic [COORD_BITS-1:0]        pos,
    logic signed [DELTA_BITS-1:0] dlt,
    logic [COORD_BITS-1:0]        lim
  );
    logic signed [SumW-1:0] p;
    logic signed [SumW-1:0] l;
    p = $signed({{(SumW-COORD_BITS){1'b0}}, pos}) +
        $signed({{(SumW-DELTA_BITS){dlt[DELTA_BITS-1]}}, dlt});
    l = $signed({{(SumW-COORD_BITS){1'b0}}, lim});
    if (p < 0) begin
      return '0;
    end else if (p > l) begin
      return lim;
    end else begin
      return p[COORD_BITS-1:0];
    end
  endfunction

  // classify the report against the stored cursor
  always_comb begin
    lim_x           = limit_m1(width_q);
    lim_y           = limit_m1(height_q);
    new_x           = clamp_axis(cur_x_q, delta_x_i, lim_x);
    new_y           = clamp_axis(cur_y_q, delta_y_i, lim_y);
    flags.moved     = (new_x != cur_x_q) || (new_y != cur_y_q);
    flags.left_chg  = left_level_i != left_q;
    flags.right_chg = right_level_i != right_q;
    flags.left_lvl  = left_level_i;
    flags.right_lvl = right_level_i;
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // reports that change nothing leave no entry behind
  assign q_push_o  = accept && (flags.moved || flags.left_chg || flags.right_chg);
  assign q_pos_x_o = new_x;
  assign q_pos_y_o = new_y;
  assign q_flags_o = flags;

  // cursor, button and configuration next state
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    left_d   = left_q;
    right_d  = right_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScreenWidth:  width_d  = cfg_wdata_i;
        CfgScreenHeight: height_d = cfg_wdata_i;
        default: ;
      endcase
    end
    if (accept) begin
      cur_x_d = new_x;
      cur_y_d = new_y;
      left_d  = left_level_i;
      right_d = right_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
      cur_x_q  <= COORD_BITS'(ScreenWidthRst >> 1);
      cur_y_q  <= COORD_BITS'(ScreenHeightRst >> 1);
      left_q   <= 1'b0;
      right_q  <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      left_q   <= left_d;
      right_q  <= right_d;
    end
  end

  // an entry always carries at least one event
  a_push_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> (q_flags_o.moved || q_flags_o.left_chg || q_flags_o.right_chg))
    else $error("front pushed an entry without events");

  // the stored cursor stays inside the clamp window of its report
  a_cursor_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (cur_x_q <= $past(lim_x)) && (cur_y_q <= $past(lim_y)))
    else $error("cursor left the screen window");

  // no push into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_i |-> !q_push_o)
    else $error("push while queue full");

endmodule

>>> rtl/mcet_fifo.sv
module mcet_fifo
  import mcet_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count update with wraparound
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

>>> rtl/mcet_back.sv
module mcet_back
  import mcet_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // queue read side
  input  logic                  q_valid_i,
  input  logic [COORD_BITS-1:0] q_pos_x_i,
  input  logic [COORD_BITS-1:0] q_pos_y_i,
  input  evt_flags_t            q_flags_i,
  output logic                  q_pop_o,
  // event output
  output logic                  ev_valid_o,
  input  logic                  ev_ready_i,
  output evt_kind_e             ev_kind_o,
  output logic [COORD_BITS-1:0] ev_pos_x_o,
  output logic [COORD_BITS-1:0] ev_pos_y_o,
  output logic [1:0]            ev_mask_o,
  output btn_sel_e              ev_button_o,
  output logic                  ev_redraw_o,
  output logic                  ev_last_o
);

  // pending events of the report being drained: bit0 move, bit1 left, bit2 right
  logic [2:0]            pend_q, pend_d;
  logic [COORD_BITS-1:0] cur_x_q;
  logic [COORD_BITS-1:0] cur_y_q;
  evt_flags_t            cur_flags_q;

  logic                  out_valid_q, out_valid_d;
  evt_kind_e             out_kind_q, out_kind_d;
  logic [COORD_BITS-1:0] out_x_q, out_x_d;
  logic [COORD_BITS-1:0] out_y_q, out_y_d;
  logic [1:0]            out_mask_q, out_mask_d;
  btn_sel_e              out_btn_q, out_btn_d;
  logic                  out_redraw_q, out_redraw_d;
  logic                  out_last_q, out_last_d;

  logic                  use_cur;
  logic [2:0]            src_pend;
  logic [2:0]            first;
  logic [2:0]            rem;
  logic [COORD_BITS-1:0] src_x, src_y;
  evt_flags_t            src_flags;
  logic                  adv;
  logic                  fire;

  // pick the source: leftover events first, else the queue head
  always_comb begin
    use_cur   = pend_q != '0;
    src_x     = use_cur ? cur_x_q : q_pos_x_i;
    src_y     = use_cur ? cur_y_q : q_pos_y_i;
    src_flags = use_cur ? cur_flags_q : q_flags_i;
    if (use_cur) begin
      src_pend = pend_q;
    end else if (q_valid_i) begin
      src_pend = {q_flags_i.right_chg, q_flags_i.left_chg, q_flags_i.moved};
    end else begin
      src_pend = '0;
    end
    first = src_pend & (~src_pend + 3'd1);
    rem   = src_pend & ~first;
    adv   = !out_valid_q || ev_ready_i;
    fire  = adv && (src_pend != '0);
  end

  assign q_pop_o = fire && !use_cur;

  // build the next event beat
  always_comb begin
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_mask_d   = out_mask_q;
    out_btn_d    = out_btn_q;
    out_redraw_d = out_redraw_q;
    out_last_d   = out_last_q;
    if (fire) begin
      pend_d      = rem;
      out_valid_d = 1'b1;
      out_x_d     = src_x;
      out_y_d     = src_y;
      out_mask_d  = {src_flags.right_lvl, src_flags.left_lvl};
      out_last_d  = rem == '0;
      out_redraw_d = (rem == '0) && (src_flags.moved || src_flags.left_chg);
      if (first[0]) begin
        out_kind_d = EvMove;
        out_btn_d  = BtnNone;
      end else if (first[1]) begin
        out_kind_d = src_flags.left_lvl ? EvDown : EvUp;
        out_btn_d  = BtnLeft;
      end else begin
        out_kind_d = src_flags.right_lvl ? EvDown : EvUp;
        out_btn_d  = BtnRight;
      end
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_x_q     <= q_pos_x_i;
      cur_y_q     <= q_pos_y_i;
      cur_flags_q <= q_flags_i;
    end
    out_kind_q   <= out_kind_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
    out_mask_q   <= out_mask_d;
    out_btn_q    <= out_btn_d;
    out_redraw_q <= out_redraw_d;
    out_last_q   <= out_last_d;
  end

  assign ev_valid_o  = out_valid_q;
  assign ev_kind_o   = out_kind_q;
  assign ev_pos_x_o  = out_x_q;
  assign ev_pos_y_o  = out_y_q;
  assign ev_mask_o   = out_mask_q;
  assign ev_button_o = out_btn_q;
  assign ev_redraw_o = out_redraw_q;
  assign ev_last_o   = out_last_q;

  // the redraw flag only ever rides on the closing beat
  a_redraw_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_o && ev_redraw_o) |-> ev_last_o)
    else $error("redraw flag on a non-final beat");

  // a new entry is taken only once the previous report is drained
  a_pop_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (pend_q == '0))
    else $error("queue popped with events still pending");

  // a move event never names a button
  a_move_no_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_o && (ev_kind_o == EvMove)) |-> (ev_button_o == BtnNone))
    else $error("move event with a button");

endmodule

>>> rtl/mouse_cursor_event_tracker_unit.sv
// first event beat: the report is written into the queue, and the back end then loads
//   its event register from the queue head
// throughput: one report per cycle when it causes at most one event and the output is
//   not stalled; else one event at a time, bounded by the single event register of the back end
// reports that change nothing are absorbed
// reset: cursor at half the reset screen size (512, 384), buttons released,
//   screen size 1024 x 768, queue and output empty
module mouse_cursor_event_tracker_unit
  import mcet_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int DELTA_BITS = DeltaBitsDef,
  localparam int InDataW   = ((2 * DELTA_BITS + 2 + 7) / 8) * 8,
  localparam int OutBits   = 2 * COORD_BITS + 5,
  localparam int OutDataW  = ((OutBits + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // report stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // delta_x, delta_y, left_level, right_level (lowest bits first)
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // event stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // pos_x, pos_y, button_mask, changed_button, redraw_cursor (lowest bits first)
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // event_kind
  output logic [1:0]          m_axis_tuser_o,
  output logic                m_axis_tlast_o,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  localparam int FlagW = $bits(evt_flags_t);
  localparam int RecW  = 2 * COORD_BITS + FlagW;

  logic signed [DELTA_BITS-1:0] delta_x;
  logic signed [DELTA_BITS-1:0] delta_y;
  logic                         left_level;
  logic                         right_level;

  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_valid;
  logic [COORD_BITS-1:0] push_x, push_y;
  evt_flags_t            push_flags;
  logic [RecW-1:0]       q_wdata, q_rdata;
  logic [COORD_BITS-1:0] head_x, head_y;
  evt_flags_t            head_flags;

  evt_kind_e             ev_kind;
  logic [COORD_BITS-1:0] ev_x, ev_y;
  logic [1:0]            ev_mask;
  btn_sel_e              ev_button;
  logic                  ev_redraw;

  // unpack the report beat
  assign delta_x     = $signed(s_axis_tdata_i[DELTA_BITS-1:0]);
  assign delta_y     = $signed(s_axis_tdata_i[2*DELTA_BITS-1:DELTA_BITS]);
  assign left_level  = s_axis_tdata_i[2*DELTA_BITS];
  assign right_level = s_axis_tdata_i[2*DELTA_BITS+1];

  mcet_front #(
    .COORD_BITS (COORD_BITS),
    .DELTA_BITS (DELTA_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .delta_x_i     (delta_x),
    .delta_y_i     (delta_y),
    .left_level_i  (left_level),
    .right_level_i (right_level),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_pos_x_o     (push_x),
    .q_pos_y_o     (push_y),
    .q_flags_o     (push_flags)
  );

  // queue entry: flags over position
  assign q_wdata    = {push_flags, push_y, push_x};
  assign head_x     = q_rdata[COORD_BITS-1:0];
  assign head_y     = q_rdata[2*COORD_BITS-1:COORD_BITS];
  assign head_flags = evt_flags_t'(q_rdata[RecW-1:2*COORD_BITS]);

  mcet_fifo #(
    .WIDTH (RecW),
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  mcet_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pos_x_i   (head_x),
    .q_pos_y_i   (head_y),
    .q_flags_i   (head_flags),
    .q_pop_o     (q_pop),
    .ev_valid_o  (m_axis_tvalid_o),
    .ev_ready_i  (m_axis_tready_i),
    .ev_kind_o   (ev_kind),
    .ev_pos_x_o  (ev_x),
    .ev_pos_y_o  (ev_y),
    .ev_mask_o   (ev_mask),
    .ev_button_o (ev_button),
    .ev_redraw_o (ev_redraw),
    .ev_last_o   (m_axis_tlast_o)
  );

  // pack the event beat
  assign m_axis_tdata_o = OutDataW'({ev_redraw, 2'(ev_button), ev_mask, ev_y, ev_x});
  assign m_axis_tuser_o = 2'(ev_kind);

endmodule
